// ===== rtl/uvam_pkg.sv =====
// ----------------------------------------------------------------------------
// uvam_pkg
// Shared constants, types and arithmetic helpers for the uv affine matrix
// builder: fixed-point widths, cordic constants and the atan table.
// ----------------------------------------------------------------------------
package uvam_pkg;

	// number of cordic micro-rotations, one pipeline stage each (8 to 30)
	localparam int CORDIC_STAGES = 24;

	// payload width of every field, Q16.16 or Q3.29
	localparam int DW = 32;
	// cordic x and y, Q2.30 with headroom
	localparam int XW = 33;
	// cordic angle, Q2.30 covering a doubled 32-bit input
	localparam int ZW = 34;
	// rounded product before saturation
	localparam int RW = 36;
	// total register stages from input to output
	localparam int LATENCY = CORDIC_STAGES + 4;

	typedef logic signed [DW-1:0] fix_t;
	typedef logic signed [XW-1:0] cxy_t;
	typedef logic signed [ZW-1:0] cz_t;
	typedef logic signed [2*DW-1:0] prod_t;
	typedef logic signed [RW-1:0] rnd_t;

	localparam cz_t  HALF_PI = 34'sd1686629713;
	localparam cz_t  PI      = 34'sd3373259426;
	localparam cxy_t GAIN    = 33'sd652032874;
	localparam prod_t RND    = 64'sd536870912;
	// bound on |cos| and |sin| out of the cordic, Q2.30 with a small margin
	localparam fix_t TRIG_MAX = 32'sd1073741888;

	// atan(2^-k) in Q2.30, rounded to nearest
	function automatic cz_t atan_q30(input logic [4:0] k);
		cz_t a;
		unique case (k)
			5'd0: a = 34'sd843314857;
			5'd1: a = 34'sd497837829;
			5'd2: a = 34'sd263043837;
			5'd3: a = 34'sd133525159;
			5'd4: a = 34'sd67021687;
			5'd5: a = 34'sd33543516;
			5'd6: a = 34'sd16775851;
			5'd7: a = 34'sd8388437;
			5'd8: a = 34'sd4194283;
			5'd9: a = 34'sd2097149;
			5'd10: a = 34'sd1048576;
			5'd11: a = 34'sd524288;
			5'd12: a = 34'sd262144;
			5'd13: a = 34'sd131072;
			5'd14: a = 34'sd65536;
			5'd15: a = 34'sd32768;
			5'd16: a = 34'sd16384;
			5'd17: a = 34'sd8192;
			5'd18: a = 34'sd4096;
			5'd19: a = 34'sd2048;
			5'd20: a = 34'sd1024;
			5'd21: a = 34'sd512;
			5'd22: a = 34'sd256;
			5'd23: a = 34'sd128;
			5'd24: a = 34'sd64;
			5'd25: a = 34'sd32;
			5'd26: a = 34'sd16;
			5'd27: a = 34'sd8;
			5'd28: a = 34'sd4;
			5'd29: a = 34'sd2;
			5'd30: a = 34'sd1;
			5'd31: a = 34'sd0;
		endcase
		return a;
	endfunction

	// Q16.16 x Q2.30 product back to Q16.16, round half up
	function automatic rnd_t round_q30(input prod_t p);
		prod_t t;
		t = (p + RND) >>> 30;
		return $signed(t[RW-1:0]);
	endfunction

	// clamp to the signed 32-bit range
	function automatic fix_t sat32(input rnd_t v);
		fix_t r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = $signed(v[DW-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/uvam_if.sv =====
// ----------------------------------------------------------------------------
// uvam_in_if / uvam_out_if
// Valid/ready channels of the uv affine matrix builder: the transform beat
// going in and the matrix beat coming out.
// ----------------------------------------------------------------------------

// transform beat: offset, angle, scale
interface uvam_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic signed [31:0] angle;
	logic signed [31:0] scale_x;
	logic signed [31:0] scale_y;

	modport source (
		output valid, offset_x, offset_y, angle, scale_x, scale_y,
		input  ready
	);
	modport sink (
		input  valid, offset_x, offset_y, angle, scale_x, scale_y,
		output ready
	);
endinterface

// matrix beat: the two variable rows
interface uvam_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] m00;
	logic signed [31:0] m01;
	logic signed [31:0] m02;
	logic signed [31:0] m10;
	logic signed [31:0] m11;
	logic signed [31:0] m12;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12,
		input  ready
	);
	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12,
		output ready
	);
endinterface

// ===== rtl/uv_affine_matrix_build.sv =====
// Throughput: one beat per cycle; every stage advances together, held only while the
// output register is full and not taken.
// Stages: angle fold, one cordic micro-rotation per stage, sign fix, 32x32 multiply,
// round and saturate into the output register.
// Reset: arst_n clears the valid bits only; the block keeps no other state.
// ----------------------------------------------------------------------------
// uv_affine_matrix_build
// Builds the two variable rows of a 2D affine uv matrix from offset, rotation
// and scale: pipelined cordic for cos/sin, then scale products in Q16.16.
// ----------------------------------------------------------------------------
module uv_affine_matrix_build import uvam_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	uvam_in_if.sink    in_ch,
	uvam_out_if.source out_ch
);

	localparam int N = CORDIC_STAGES;

	// global advance: the whole pipe moves unless the output beat is stuck
	logic adv;

	// cordic stage registers, index = stages completed (0 = folded angle)
	logic [N:0] vld_sc;
	logic       flip_sc [0:N];
	cxy_t       x_sc [1:N];
	cxy_t       y_sc [1:N];
	cz_t        z_sc [0:N-1];
	fix_t       tx_sc [0:N];
	fix_t       ty_sc [0:N];
	fix_t       sx_sc [0:N];
	fix_t       sy_sc [0:N];

	// sign fix stage
	logic vld_st;
	fix_t c_st, s_st, tx_st, ty_st, sx_st, sy_st;

	// multiply stage
	logic  vld_sm;
	prod_t p00_sm, p01_sm, p10_sm, p11_sm;
	fix_t  tx_sm, ty_sm;

	// output stage
	logic vld_so;
	fix_t m00_so, m01_so, m02_so, m10_so, m11_so, m12_so;

	// angle fold
	cz_t  z_in, z_fold;
	logic flip_in;

	assign adv = !vld_so || out_ch.ready;
	assign in_ch.ready = adv;

	// double Q3.29 to Q2.30 and fold into +-pi/2
	always_comb begin
		z_in = ZW'($signed({in_ch.angle, 1'b0}));
		priority if (z_in > HALF_PI) begin
			z_fold  = z_in - PI;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI) begin
			z_fold  = z_in + PI;
			flip_in = 1'b1;
		end else begin
			z_fold  = z_in;
			flip_in = 1'b0;
		end
	end

	// fold stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc[0] <= 1'b0;
		end else if (adv) begin
			vld_sc[0] <= in_ch.valid;
		end
	end

	// fold stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			z_sc[0]    <= z_fold;
			flip_sc[0] <= flip_in;
			tx_sc[0]   <= in_ch.offset_x;
			ty_sc[0]   <= in_ch.offset_y;
			sx_sc[0]   <= in_ch.scale_x;
			sy_sc[0]   <= in_ch.scale_y;
		end
	end

	// cordic micro-rotations, one per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic [4:0] K = 5'(i);
		cxy_t xi, yi, xn, yn;

		if (i == 0) begin : g_first
			assign xi = GAIN;
			assign yi = '0;
		end else begin : g_rest
			assign xi = x_sc[i];
			assign yi = y_sc[i];
		end

		// rotate toward zero residual angle
		always_comb begin
			if (!z_sc[i][ZW-1]) begin
				xn = xi - (yi >>> K);
				yn = yi + (xi >>> K);
			end else begin
				xn = xi + (yi >>> K);
				yn = yi - (xi >>> K);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sc[i+1] <= 1'b0;
			end else if (adv) begin
				vld_sc[i+1] <= vld_sc[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				x_sc[i+1]    <= xn;
				y_sc[i+1]    <= yn;
				flip_sc[i+1] <= flip_sc[i];
				tx_sc[i+1]   <= tx_sc[i];
				ty_sc[i+1]   <= ty_sc[i];
				sx_sc[i+1]   <= sx_sc[i];
				sy_sc[i+1]   <= sy_sc[i];
			end
		end

		// residual angle is not needed after the last rotation
		if (i < N - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (adv) begin
					z_sc[i+1] <= z_sc[i][ZW-1] ? z_sc[i] + atan_q30(K)
						: z_sc[i] - atan_q30(K);
				end
			end
		end
	end

	// control of the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_st <= 1'b0;
			vld_sm <= 1'b0;
			vld_so <= 1'b0;
		end else if (adv) begin
			vld_st <= vld_sc[N];
			vld_sm <= vld_st;
			vld_so <= vld_sm;
		end
	end

	// undo the fold, multiply, then round and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			c_st  <= flip_sc[N] ? DW'(-x_sc[N]) : DW'(x_sc[N]);
			s_st  <= flip_sc[N] ? DW'(-y_sc[N]) : DW'(y_sc[N]);
			tx_st <= tx_sc[N];
			ty_st <= ty_sc[N];
			sx_st <= sx_sc[N];
			sy_st <= sy_sc[N];

			p00_sm <= sx_st * c_st;
			p01_sm <= sx_st * s_st;
			p10_sm <= sy_st * s_st;
			p11_sm <= sy_st * c_st;
			tx_sm  <= tx_st;
			ty_sm  <= ty_st;

			m00_so <= sat32(round_q30(p00_sm));
			m01_so <= sat32(round_q30(p01_sm));
			m02_so <= tx_sm;
			m10_so <= sat32(-round_q30(p10_sm));
			m11_so <= sat32(round_q30(p11_sm));
			m12_so <= ty_sm;
		end
	end

	assign out_ch.valid = vld_so;
	assign out_ch.m00   = m00_so;
	assign out_ch.m01   = m01_so;
	assign out_ch.m02   = m02_so;
	assign out_ch.m10   = m10_so;
	assign out_ch.m11   = m11_so;
	assign out_ch.m12   = m12_so;

	// an accepted beat lands in the fold stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_sc[0])
		else $error("accepted beat missing from fold stage");

	// a stall freezes every valid bit in the pipe
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_sc) && $stable(vld_st) && $stable(vld_sm) && $stable(vld_so))
		else $error("pipe moved during stall");

	// folded angle lies within the cordic convergence range
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sc[0] |-> (z_sc[0] <= HALF_PI) && (z_sc[0] >= -HALF_PI))
		else $error("folded angle out of range");

	// cordic cos and sin each stay within +-TRIG_MAX
	a_trig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_st |-> (c_st <= TRIG_MAX) && (c_st >= -TRIG_MAX)
			&& (s_st <= TRIG_MAX) && (s_st >= -TRIG_MAX))
		else $error("cordic output exceeds unit magnitude");

endmodule
